// ===== rtl/core/dqb_pkg.sv =====
// Shared constants, codes and header byte table for the DNS query builder.
package dqb_pkg;

  // Default limits of the name encoder
  localparam int DQB_MAX_LABEL = 63;
  localparam int DQB_MAX_NAME  = 253;

  // Fixed field widths
  localparam int NAME_LEN_W = 8;
  localparam logic [NAME_LEN_W-1:0] NAME_LEN_SAT = 8'hFF;

  // Input item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Result error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_EMPTY_NAME = 2'd1;
  localparam logic [1:0] ERR_NAME_LEN   = 2'd2;
  localparam logic [1:0] ERR_LABEL_LEN  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_TXID  = 1'b0;
  localparam logic CFG_QTYPE = 1'b1;

  localparam logic [15:0] TXID_RESET  = 16'h1234;
  localparam logic [15:0] QTYPE_RESET = 16'h0001;
  localparam logic [15:0] HDR_FLAGS   = 16'h0100;
  localparam logic [15:0] QDCOUNT     = 16'h0001;
  localparam logic [15:0] CLASS_IN    = 16'h0001;

  // Byte positions within the header and the trailer
  localparam logic [3:0] HDR_LAST  = 4'd11;
  localparam logic [3:0] TAIL_LAST = 4'd4;

  // Byte count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // Header byte at a position: id, flags, one question, three zero counts
  function automatic logic [7:0] hdr_byte(input logic [3:0] pos, input logic [15:0] txid);
    logic [7:0] b;
    case (pos)
      4'd0:    b = txid[15:8];
      4'd1:    b = txid[7:0];
      4'd2:    b = HDR_FLAGS[15:8];
      4'd3:    b = HDR_FLAGS[7:0];
      4'd4:    b = QDCOUNT[15:8];
      4'd5:    b = QDCOUNT[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Trailer byte at a position: root label, query type, class
  function automatic logic [7:0] tail_byte(input logic [3:0] pos, input logic [15:0] qtype);
    logic [7:0] b;
    case (pos)
      4'd1:    b = qtype[15:8];
      4'd2:    b = qtype[7:0];
      4'd3:    b = CLASS_IN[15:8];
      4'd4:    b = CLASS_IN[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/dns_query_builder_core.sv =====
// DNS query builder: label encoding of a hostname into a packed query stream.
// A character item is taken in idle; the first one of a query adds 12 bytes of
// header, a dot that closes a label adds a length byte and the label bytes, read
// from the label RAM. The end item adds label, trailer and flush, or an error beat.
// Output words are paced by the byte packer at one byte per cycle unless the output stalls.
// Synchronous reset clears control state and sets the registers to 0x1234 and 1.
module dns_query_builder_core
  import dqb_pkg::*;
#(
  parameter int MAX_LABEL = DQB_MAX_LABEL,
  parameter int MAX_NAME  = DQB_MAX_NAME
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  name_char,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] data_word,
  output logic [1:0]  byte_count,
  output logic        end_of_query,
  output logic [1:0]  error_code
);

  localparam int LW = $clog2(MAX_LABEL + 1);
  localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_LEN,
    S_LBL,
    S_TAIL,
    S_FLUSH,
    S_ERR
  } state_t;

  state_t state;

  logic [15:0]           transaction_id;
  logic [15:0]           query_type;
  logic [LW-1:0]         label_length;
  logic [NAME_LEN_W-1:0] name_length;
  logic                  header_sent;
  logic                  previous_was_dot;
  logic                  held_error;
  logic [7:0]            carry_byte;
  logic                  carry_valid;
  logic                  end_mode;
  logic [LW-1:0]         emit_len;
  logic [LW-1:0]         lbl_idx;
  logic [3:0]            step;
  logic [1:0]            err_hold;

  logic                  in_fire;
  logic                  out_free;
  logic                  out_load;
  logic                  emitting;
  logic                  push;
  logic                  tail_last;
  logic [7:0]            cur_byte;
  logic [LW-1:0]         idx_inc;
  logic [NAME_LEN_W-1:0] stripped;
  logic [1:0]            end_err;
  logic                  is_dot;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [7:0]            ram_rdata;

  // Handshake and pacing
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign emitting = (state == S_HDR) || (state == S_LEN) || (state == S_LBL) ||
                    (state == S_TAIL);
  assign push      = emitting && (!carry_valid || out_free);
  assign tail_last = (state == S_TAIL) && (step == TAIL_LAST);
  assign is_dot    = (name_char == DOT_CHAR);
  assign out_load  = (push && carry_valid) ||
                     (out_free && ((state == S_FLUSH) || (state == S_ERR)));

  // Select the byte that goes to the packer this cycle
  always_comb begin
    case (state)
      S_HDR:   cur_byte = hdr_byte(step, transaction_id);
      S_LEN:   cur_byte = 8'(emit_len);
      S_LBL:   cur_byte = ram_rdata;
      S_TAIL:  cur_byte = tail_byte(step, query_type);
      default: cur_byte = 8'h00;
    endcase
  end

  // Classify the end item
  assign stripped = name_length - {{(NAME_LEN_W-1){1'b0}}, previous_was_dot};
  always_comb begin
    if (name_length == '0) begin
      end_err = ERR_EMPTY_NAME;
    end else if (stripped == '0 || stripped > NAME_LEN_W'(MAX_NAME)) begin
      end_err = ERR_NAME_LEN;
    end else if (held_error) begin
      end_err = ERR_LABEL_LEN;
    end else begin
      end_err = ERR_NONE;
    end
  end

  // Label RAM: store accepted label characters, prefetch one entry ahead on emission
  assign idx_inc   = lbl_idx + LW'(1);
  assign ram_we    = in_fire && (kind == KIND_CHAR) && !is_dot &&
                     (label_length < LW'(MAX_LABEL));
  assign ram_waddr = label_length[AW-1:0];
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state == S_LEN) begin
      ram_re = 1'b1;
    end else if (state == S_LBL) begin
      ram_re    = push && (idx_inc < emit_len);
      ram_raddr = idx_inc[AW-1:0];
    end
  end

  dqb_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LABEL)
  ) u_label_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (name_char),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, byte packer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      transaction_id   <= TXID_RESET;
      query_type       <= QTYPE_RESET;
      label_length     <= '0;
      name_length      <= '0;
      header_sent      <= 1'b0;
      previous_was_dot <= 1'b0;
      held_error       <= 1'b0;
      carry_valid      <= 1'b0;
      end_mode         <= 1'b0;
      step             <= '0;
      lbl_idx          <= '0;
      out_valid        <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TXID:  transaction_id <= cfg_data;
          CFG_QTYPE: query_type     <= cfg_data;
          default:   ;
        endcase
      end

      // drop the output beat once taken, unless a new one loads
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      // pack bytes into words, first byte in the upper half
      if (push) begin
        if (carry_valid) begin
          out_valid    <= 1'b1;
          data_word    <= {carry_byte, cur_byte};
          byte_count   <= CNT_TWO;
          end_of_query <= tail_last;
          error_code   <= ERR_NONE;
          carry_valid  <= 1'b0;
        end else begin
          carry_byte  <= cur_byte;
          carry_valid <= 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (kind == KIND_END) begin
              // close the query and clear its state
              label_length     <= '0;
              name_length      <= '0;
              header_sent      <= 1'b0;
              previous_was_dot <= 1'b0;
              held_error       <= 1'b0;
              end_mode         <= 1'b1;
              step             <= '0;
              emit_len         <= label_length;
              err_hold         <= end_err;
              if (end_err != ERR_NONE) begin
                state <= S_ERR;
              end else if (label_length != '0) begin
                state <= S_LEN;
              end else begin
                state <= S_TAIL;
              end
            end else begin
              if (name_length != NAME_LEN_SAT) begin
                name_length <= name_length + NAME_LEN_W'(1);
              end
              if (!header_sent) begin
                header_sent <= 1'b1;
                step        <= '0;
                state       <= S_HDR;
              end
              if (is_dot) begin
                // a dot closes the label; an empty one is an error
                if (label_length == '0) begin
                  held_error <= 1'b1;
                end else if (!held_error) begin
                  emit_len <= label_length;
                  end_mode <= 1'b0;
                  state    <= S_LEN;
                end
                label_length     <= '0;
                previous_was_dot <= 1'b1;
              end else begin
                previous_was_dot <= 1'b0;
                if (label_length >= LW'(MAX_LABEL)) begin
                  held_error <= 1'b1;
                end else begin
                  label_length <= label_length + LW'(1);
                end
              end
            end
          end
        end

        S_HDR: begin
          if (push) begin
            if (step == HDR_LAST) begin
              state <= S_IDLE;
            end else begin
              step <= step + 4'd1;
            end
          end
        end

        S_LEN: begin
          if (push) begin
            lbl_idx <= '0;
            state   <= S_LBL;
          end
        end

        S_LBL: begin
          if (push) begin
            if (idx_inc == emit_len) begin
              step  <= '0;
              state <= end_mode ? S_TAIL : S_IDLE;
            end else begin
              lbl_idx <= idx_inc;
            end
          end
        end

        S_TAIL: begin
          if (push) begin
            if (step == TAIL_LAST) begin
              // an odd byte count leaves one byte to flush
              state <= carry_valid ? S_IDLE : S_FLUSH;
            end else begin
              step <= step + 4'd1;
            end
          end
        end

        S_FLUSH: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            data_word    <= {carry_byte, 8'h00};
            byte_count   <= CNT_ONE;
            end_of_query <= 1'b1;
            error_code   <= ERR_NONE;
            carry_valid  <= 1'b0;
            state        <= S_IDLE;
          end
        end

        S_ERR: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            data_word    <= '0;
            byte_count   <= CNT_NONE;
            end_of_query <= 1'b1;
            error_code   <= err_hold;
            carry_valid  <= 1'b0;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A new query always starts with an empty packer
  a_fresh_query_no_carry: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !header_sent) |-> !carry_valid)
    else $error("carry byte left over at query start");

  // Label RAM is never written while a label is being read back
  a_no_write_during_read: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE))
    else $error("label RAM written outside idle");

  // Error results carry no bytes and close the query
  a_error_beat_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != ERR_NONE) |-> (byte_count == CNT_NONE && end_of_query))
    else $error("malformed error beat");

  // An output beat is never overwritten before it is taken
  a_beat_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(data_word) && $stable(byte_count)))
    else $error("output beat changed while stalled");

endmodule

// ===== rtl/core/dqb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dqb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== test/tb_dns_query_builder_core.sv =====
// Self-checking testbench for the DNS query builder core: header, label and trailer stream.
`timescale 1ns / 100ps

module tb_dns_query_builder_core;
  import dqb_pkg::*;

  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 80;    // settling time after the last expected word
  localparam int STALL_LIMIT  = 4000;  // cycles without any beat before giving up
  localparam int RANDOM_ITEMS = 40;
  localparam int LONG_NAME    = 256;   // past the name limit and the count saturation

  // One expected output beat
  typedef struct packed {
    logic [15:0] word;
    logic [1:0]  count;
    logic        eoq;
    logic [1:0]  err;
  } qword_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = CFG_TXID;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KIND_CHAR;
  logic [7:0]  name_char = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] data_word;
  logic [1:0]  byte_count;
  logic        end_of_query;
  logic [1:0]  error_code;

  // Encoder mirror: registers and per-query state
  logic [15:0] txid_reg;
  logic [15:0] qtype_reg;
  logic [7:0]  lbl_bytes [DQB_MAX_LABEL];
  int          lbl_len;
  logic [NAME_LEN_W-1:0] name_len;
  bit          hdr_done;
  bit          last_dot;
  logic [1:0]  held_err;
  logic [7:0]  carry_b;
  bit          carry_v;

  qword_t query_words_q[$];

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_req   = 1'b0;
  int fail_count    = 0;
  int items_sent    = 0;
  int words_seen    = 0;
  int queries_done  = 0;
  int error_queries = 0;

  dns_query_builder_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .name_char    (name_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .end_of_query (end_of_query),
    .error_code   (error_code)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Encoder mirror
  // ---------------------------------------------------------------------------

  function automatic void clear_query_state();
    lbl_len  = 0;
    name_len = '0;
    hdr_done = 1'b0;
    last_dot = 1'b0;
    held_err = ERR_NONE;
    carry_b  = 8'h00;
    carry_v  = 1'b0;
  endfunction

  function automatic void put_word(input logic [15:0] word, input logic [1:0] count);
    qword_t w;
    w.word  = word;
    w.count = count;
    w.eoq   = 1'b0;
    w.err   = ERR_NONE;
    query_words_q = {query_words_q, w};
  endfunction

  // Pair bytes into words, first byte in the upper half
  function automatic void push_byte(input logic [7:0] b);
    if (carry_v) begin
      carry_v = 1'b0;
      put_word({carry_b, b}, CNT_TWO);
    end else begin
      carry_b = b;
      carry_v = 1'b1;
    end
  endfunction

  function automatic void push_u16(input logic [15:0] v);
    push_byte(v[15:8]);
    push_byte(v[7:0]);
  endfunction

  function automatic void emit_label();
    int i;
    push_byte(8'(lbl_len));
    for (i = 0; i < lbl_len; i++) push_byte(lbl_bytes[i]);
  endfunction

  // Work out the words that one accepted item produces
  function automatic void encode_item(input logic k, input logic [7:0] c);
    int stripped;
    logic [1:0] err;
    qword_t w;
    if (k == KIND_CHAR) begin
      if (!hdr_done) begin
        push_u16(txid_reg);
        push_u16(HDR_FLAGS);
        push_u16(QDCOUNT);
        push_u16(16'h0000);
        push_u16(16'h0000);
        push_u16(16'h0000);
        hdr_done = 1'b1;
      end
      if (name_len < NAME_LEN_SAT) name_len++;
      if (c == DOT_CHAR) begin
        if (lbl_len == 0) held_err = ERR_LABEL_LEN;
        else if (held_err == ERR_NONE) emit_label();
        lbl_len  = 0;
        last_dot = 1'b1;
      end else begin
        last_dot = 1'b0;
        if (lbl_len >= DQB_MAX_LABEL) held_err = ERR_LABEL_LEN;
        else begin
          lbl_bytes[lbl_len] = c;
          lbl_len++;
        end
      end
    end else begin
      // Pick the error by priority: empty name, name length, label length
      err = ERR_NONE;
      if (name_len == 0) err = ERR_EMPTY_NAME;
      else begin
        stripped = int'(name_len);
        if (last_dot) stripped--;
        if (stripped == 0 || stripped > DQB_MAX_NAME) err = ERR_NAME_LEN;
        else if (held_err != ERR_NONE) err = ERR_LABEL_LEN;
      end
      if (err != ERR_NONE) begin
        w.word  = 16'h0000;
        w.count = CNT_NONE;
        w.eoq   = 1'b1;
        w.err   = err;
        query_words_q = {query_words_q, w};
      end else begin
        if (lbl_len > 0) emit_label();
        push_byte(8'h00);
        push_u16(qtype_reg);
        push_u16(CLASS_IN);
        if (carry_v) begin
          carry_v = 1'b0;
          put_word({carry_b, 8'h00}, CNT_ONE);
        end
        // Mark the last word of the query
        query_words_q[query_words_q.size() - 1].eoq = 1'b1;
      end
      clear_query_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_label_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == DOT_CHAR) c = 8'h2D;
    return c;
  endfunction

  task automatic report_error(input string msg);
    fail_count++;
    $display("mismatch at %0t ns: %s", $realtime, msg);
  endtask

  // Offer one item and hold it until the beat
  task automatic send_item(input logic k, input logic [7:0] c);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    name_char <= c;
    do @(posedge clk); while (in_ready !== 1'b1);
    encode_item(k, c);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    logic [7:0] c;
    for (i = 0; i < s.len(); i++) begin
      c = s[i];
      send_item(KIND_CHAR, c);
    end
    send_item(KIND_END, 8'h00);
  endtask

  // Name of a given length, cut into labels of label_max bytes
  task automatic send_long_name(input int total, input int label_max, input bit trail_dot);
    int i;
    int run;
    run = 0;
    for (i = 0; i < total; i++) begin
      if (run == label_max) begin
        send_item(KIND_CHAR, DOT_CHAR);
        run = 0;
      end else begin
        send_item(KIND_CHAR, rand_label_char());
        run++;
      end
    end
    if (trail_dot) send_item(KIND_CHAR, DOT_CHAR);
    send_item(KIND_END, 8'h00);
  endtask

  // Mostly well-formed names with random bytes, some raw noise
  task automatic send_random_query();
    int n_labels;
    int len;
    int k;
    int n;
    logic [7:0] c;
    if ($urandom_range(0, 9) < 8) begin
      n_labels = $urandom_range(1, 4);
      for (k = 0; k < n_labels; k++) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 8);
        repeat (len) send_item(KIND_CHAR, rand_label_char());
        if (k < n_labels - 1 || $urandom_range(0, 4) == 0) send_item(KIND_CHAR, DOT_CHAR);
      end
    end else begin
      n = $urandom_range(0, 12);
      repeat (n) begin
        c = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) c = DOT_CHAR;
        send_item(KIND_CHAR, c);
      end
    end
    c = 8'($urandom_range(0, 255));
    send_item(KIND_END, c);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_TXID) txid_reg = value;
    else qtype_reg = value;
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected word, then let the core settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (query_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_word();
    qword_t w;
    words_seen++;
    if (query_words_q.size() == 0) begin
      report_error($sformatf("unexpected word %h count %0d", data_word, byte_count));
    end else begin
      w = query_words_q.pop_front();
      if (data_word !== w.word)
        report_error($sformatf("data_word %h, expected %h", data_word, w.word));
      if (byte_count !== w.count)
        report_error($sformatf("byte_count %0d, expected %0d", byte_count, w.count));
      if (end_of_query !== w.eoq)
        report_error($sformatf("end_of_query %b, expected %b", end_of_query, w.eoq));
      if (error_code !== w.err)
        report_error($sformatf("error_code %0d, expected %0d", error_code, w.err));
      if (w.eoq) begin
        queries_done++;
        if (w.err != ERR_NONE) error_queries++;
      end
    end
  endtask

  // Receiver: check each beat, then pick next ready
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_ready) check_word();
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) || cfg_wr_en)
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: %0d cycles without a beat, %0d words pending", quiet,
             query_words_q.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers untouched since reset
  task automatic test_reset_values();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_text("a");
    wait_drain();
  endtask

  // Short names for each special case and byte extremes
  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_text("");
    send_text("ab");
    send_text("a.b");
    send_text("x.");
    send_text("a..");
    send_text(".a");
    send_text(".");
    send_text("a..b");
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_CHAR, 8'hFF);
    send_item(KIND_CHAR, 8'h55);
    send_item(KIND_CHAR, 8'hAA);
    send_item(KIND_END, 8'hFF);
    wait_drain();
  endtask

  // Full label, overlong label, then a name past its limit and the count saturation
  task automatic test_limits();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (DQB_MAX_LABEL) send_item(KIND_CHAR, rand_label_char());
    send_item(KIND_CHAR, DOT_CHAR);
    repeat (DQB_MAX_LABEL + 1) send_item(KIND_CHAR, rand_label_char());
    send_item(KIND_CHAR, DOT_CHAR);
    repeat (LONG_NAME - 2 * DQB_MAX_LABEL - 3) send_item(KIND_CHAR, rand_label_char());
    send_item(KIND_END, 8'h00);
    wait_drain();
  endtask

  // Register extremes and random settings
  task automatic test_config_sweep();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    write_cfg(CFG_TXID, 16'h0000);
    write_cfg(CFG_QTYPE, 16'h0000);
    send_text("ns1.example");
    wait_drain();
    write_cfg(CFG_TXID, 16'hFFFF);
    write_cfg(CFG_QTYPE, 16'hFFFF);
    send_text("ns1.example");
    wait_drain();
    write_cfg(CFG_TXID, 16'h8001);
    write_cfg(CFG_QTYPE, 16'd28);
    send_text("mail.host.");
    wait_drain();
    write_cfg(CFG_TXID, 16'($urandom_range(0, 65535)));
    send_text("q");
    wait_drain();
  endtask

  // Hold the receiver off while the sender keeps offering, then pause the sender
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req = 1'b1;
    send_long_name(30, 8, 1'b0);
    send_text("b.c");
    wait_drain();
    send_text("after.pause");
    wait_drain();
  endtask

  task automatic test_random();
    int start;
    int q;
    start = items_sent;
    q = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    while (items_sent - start < RANDOM_ITEMS) begin
      send_random_query();
      q++;
      // Pick idling on or off at random for each stretch
      if (q % 5 == 0) begin
        tx_idle_on = 1'($urandom_range(0, 1));
        rx_idle_on = 1'($urandom_range(0, 1));
      end
      if (q % 8 == 0) begin
        wait_drain();
        write_cfg(CFG_TXID, 16'($urandom_range(0, 65535)));
        write_cfg(CFG_QTYPE, 16'($urandom_range(0, 65535)));
      end
    end
    wait_drain();
  endtask

  initial begin
    txid_reg  = TXID_RESET;
    qtype_reg = QTYPE_RESET;
    clear_query_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_directed();
    test_limits();
    test_config_sweep();
    test_backpressure();
    test_random();
    wait_drain();

    $display("run covered %0d input beats and %0d output words over %0d queries",
             items_sent, words_seen, queries_done);
    $display("%0d queries ended in an error word, %0d mismatches", error_queries, fail_count);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dqb_pkg.sv
rtl/core/dqb_ram.sv
rtl/core/dns_query_builder_core.sv
test/tb_dns_query_builder_core.sv
